// ===== rtl/alis_pkg.sv =====
// Package for the bounded list engine: sizes, field widths, request and
// status codes, and the control word that drives each storage cell.
// No dependencies.
`timescale 1ns / 1ps

package alis_pkg;

    localparam int CAPACITY   = 8;
    localparam int DATA_WIDTH = 32;

    localparam int FUNC_W  = 2;
    localparam int POS_W   = 4;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int FIDX_W  = 3;
    localparam int COUNT_W = 4;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [FUNC_W-1:0] FN_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FN_SEARCH = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS  = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic sample;
        logic check;
        logic load;
        logic shift;
    } alis_cell_ctrl_t;

endpackage

// ===== rtl/alis_req_if.sv =====
// Request channel: valid/ready handshake with func, position and value.
// Depends on alis_pkg.
`timescale 1ns / 1ps

interface alis_req_if
    import alis_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

// ===== rtl/alis_rsp_if.sv =====
// Result channel: valid/ready handshake with status, found_index and count.
// Depends on alis_pkg.
`timescale 1ns / 1ps

interface alis_rsp_if
    import alis_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [FIDX_W-1:0]  found_index;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output status, output found_index, output count,
                    input ready);
    modport sink   (input valid, input status, input found_index, input count,
                    output ready);
endinterface

// ===== rtl/array_list_insert_search.sv =====
// Top level of the bounded list engine: request decode, row of entry cells,
// first-match encoder and result register. Depends on alis_pkg, alis_req_if,
// alis_rsp_if and alis_cell.
//
// Usage:
//   req carries one request per transfer: func (append, insert, search,
//   clear), position (insert only) and value. rsp returns exactly one result
//   per request: status, found_index and the entry count after the request.
//   Each request goes through these steps in order: the transfer, in which
//   every cell compares its word and shifts or loads in parallel; the encode
//   step, which registers the first matching cell; then the result is held
//   on rsp. req.ready is high only while no request is in flight, so one
//   request is served at a time and a new request may transfer in the cycle
//   after the result transfers. The priority encoder over the cell match
//   bits works in the encode step.
//   A stalled receiver holds the result and blocks further requests.
//   Reset clears the entry count and all handshake state; stored words are
//   left undefined and are never read before they are written.
`timescale 1ns / 1ps

module array_list_insert_search
    import alis_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    alis_req_if.sink   req,
    alis_rsp_if.source rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_SEND
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [FUNC_W-1:0]  func_reg;
    logic [STAT_W-1:0]  pre_status_reg;
    logic [STAT_W-1:0]  pre_status_next;
    logic [STAT_W-1:0]  status_reg;
    logic [FIDX_W-1:0]  found_index_reg;

    logic                  accept;
    logic                  full;
    logic                  wr_ok;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      tgt;
    logic [DATA_WIDTH-1:0] word;

    alis_cell_ctrl_t       ctrl   [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_q [CAPACITY];
    logic [CAPACITY-1:0]   hits;

    logic                  any_hit;
    logic [IDX_W-1:0]      hit_idx;

    assign accept  = req.valid && req.ready;
    assign word    = DATA_WIDTH'(req.value);
    assign cnt_ext = CMP_W'(cnt_reg);
    assign full    = (cnt_reg >= CNT_W'(CAPACITY));

    always_comb
    begin
        pre_status_next = ST_OK;
        cnt_next        = cnt_reg;
        wr_ok           = 1'b0;
        tgt             = cnt_ext;
        case (req.func)
            FN_APPEND:
            begin
                if (full)
                begin
                    pre_status_next = ST_FULL;
                end
                else
                begin
                    wr_ok = 1'b1;
                end
            end
            FN_INSERT:
            begin
                tgt = CMP_W'(req.position);
                if (full)
                begin
                    pre_status_next = ST_FULL;
                end
                else if (CMP_W'(req.position) > cnt_ext)
                begin
                    pre_status_next = ST_BADPOS;
                end
                else
                begin
                    wr_ok = 1'b1;
                end
            end
            FN_SEARCH:
            begin
                pre_status_next = ST_MISSING;
            end
            FN_CLEAR:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
        if (wr_ok)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            ctrl[i].sample = accept;
            ctrl[i].check  = (CMP_W'(i) < cnt_ext);
            ctrl[i].load   = accept && wr_ok && (CMP_W'(i) == tgt);
            ctrl[i].shift  = accept && wr_ok && (CMP_W'(i) > tgt) && (CMP_W'(i) <= cnt_ext);
        end
    end

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left;
        if (g == 0)
        begin : g_head
            assign left = '0;
        end
        else
        begin : g_link
            assign left = cell_q[g-1];
        end
        alis_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[g]),
            .value     (word),
            .left_data (left),
            .data      (cell_q[g]),
            .hit       (hits[g])
        );
    end

    always_comb
    begin
        any_hit = 1'b0;
        hit_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                any_hit = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            func_reg        <= FN_APPEND;
            pre_status_reg  <= ST_OK;
            status_reg      <= ST_OK;
            found_index_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg        <= cnt_next;
                        func_reg       <= req.func;
                        pre_status_reg <= pre_status_next;
                        state_reg      <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    if (func_reg == FN_SEARCH && any_hit)
                    begin
                        status_reg      <= ST_OK;
                        found_index_reg <= FIDX_W'(hit_idx);
                    end
                    else
                    begin
                        status_reg      <= pre_status_reg;
                        found_index_reg <= '0;
                    end
                    state_reg <= S_SEND;
                end
                S_SEND:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = (state_reg == S_SEND);
    assign rsp.status      = status_reg;
    assign rsp.found_index = found_index_reg;
    assign rsp.count       = COUNT_W'(cnt_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !rsp.valid)
        else $error("result valid in the cycle after a request transfer");

    a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.found_index == '0)
        else $error("nonzero index on a failed request");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_FULL |-> cnt_reg == CNT_W'(CAPACITY))
        else $error("full status with room left");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE && !accept |=> $stable(cnt_reg))
        else $error("entry count changed while a request was in flight");
`endif

endmodule

// ===== rtl/alis_cell.sv =====
// One list entry: holds a data word, loads a new word or its left neighbor's
// word, and registers whether it matches the search word. Depends on alis_pkg.
`timescale 1ns / 1ps

module alis_cell
    import alis_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  alis_cell_ctrl_t       ctrl,
    input  logic [DATA_WIDTH-1:0] value,
    input  logic [DATA_WIDTH-1:0] left_data,
    output logic [DATA_WIDTH-1:0] data,
    output logic                  hit
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic                  hit_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            data_reg <= value;
        end
        else if (ctrl.shift)
        begin
            data_reg <= left_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else if (ctrl.sample)
        begin
            hit_reg <= ctrl.check && (data_reg == value);
        end
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule
